FILE: rtl/goal_heading_bang_bang_macros.svh
// assertion macros for the heading controller
// used by the top level only, needs clk and rst_n in scope
`ifndef GOAL_HEADING_BANG_BANG_MACROS_SVH
`define GOAL_HEADING_BANG_BANG_MACROS_SVH
`ifndef SYNTHESIS
`define GHBB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ghbb check failed");
`define GHBB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ghbb implication failed");
`else
`define GHBB_ASSERT(lbl, prop)
`define GHBB_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

FILE: rtl/ghbb_pkg.sv
// shared types, constants and arctangent table for the heading controller
// no dependencies
package ghbb_pkg;

  localparam int XW     = 28;
  localparam int ACC_W  = 32;
  localparam int ATAN_N = 24;

  localparam logic [2:0] REG_GOAL_X    = 3'd0;
  localparam logic [2:0] REG_GOAL_Y    = 3'd1;
  localparam logic [2:0] REG_TOLERANCE = 3'd2;
  localparam logic [2:0] REG_TURN_RATE = 3'd3;
  localparam logic [2:0] REG_DRIVE     = 3'd4;

  typedef struct packed {
    logic                    zero;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic [ACC_W-1:0]        acc;
    logic [15:0]             heading;
  } ghbb_vec_t;

  typedef struct packed {
    logic [14:0] tolerance;
    logic [14:0] turn_rate;
    logic [14:0] drive_speed;
  } ghbb_cmd_cfg_t;

  function automatic logic [ACC_W-1:0] ghbb_atan(input logic [4:0] idx);
    logic [ACC_W-1:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/ghbb_prep.sv
// first stage: goal minus pose, half-turn fold for the left half plane
// depends on ghbb_pkg
module ghbb_prep #(
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [15:0]        pos_x,
  input  logic [15:0]        pos_y,
  input  logic [15:0]        heading,
  input  logic [15:0]        goal_x,
  input  logic [15:0]        goal_y,
  output logic               valid_r,
  output ghbb_pkg::ghbb_vec_t vec_r
);
  import ghbb_pkg::*;

  localparam int CW = (COORD_BITS > 16) ? 16 : COORD_BITS;
  localparam int SH = 16 - CW;

  logic [15:0]        pxs, pys, gxs, gys;
  logic signed [15:0] px, py, gx, gy;
  logic signed [16:0] dx, dy;
  logic signed [17:0] xm, ym;
  logic               neg;
  ghbb_vec_t          vec_nxt;
  logic               valid_nxt;

  assign pxs = pos_x << SH;
  assign pys = pos_y << SH;
  assign gxs = goal_x << SH;
  assign gys = goal_y << SH;
  assign px  = $signed(pxs) >>> SH;
  assign py  = $signed(pys) >>> SH;
  assign gx  = $signed(gxs) >>> SH;
  assign gy  = $signed(gys) >>> SH;

  always_comb begin
    dx  = {gx[15], gx} - {px[15], px};
    dy  = {gy[15], gy} - {py[15], py};
    neg = dx[16];
    xm  = neg ? -{dx[16], dx} : {dx[16], dx};
    ym  = neg ? -{dy[16], dy} : {dy[16], dy};
    vec_nxt.zero    = (dx == '0) && (dy == '0);
    vec_nxt.x       = {{(XW-26){xm[17]}}, xm, 8'b0};
    vec_nxt.y       = {{(XW-26){ym[17]}}, ym, 8'b0};
    vec_nxt.acc     = neg ? 32'h80000000 : 32'h0;
    vec_nxt.heading = heading;
    valid_nxt       = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

endmodule

FILE: rtl/ghbb_cordic_stage.sv
// one vectoring cordic iteration with its own register
// depends on ghbb_pkg for the vector type and arctangent table
module ghbb_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_in,
  input  ghbb_pkg::ghbb_vec_t vec_in,
  output logic               valid_r,
  output ghbb_pkg::ghbb_vec_t vec_r
);
  import ghbb_pkg::*;

  localparam logic [ACC_W-1:0] ANGLE = ghbb_atan(5'(IDX));

  logic signed [XW-1:0] xs, ys;
  ghbb_vec_t            vec_nxt;

  assign xs = vec_in.x >>> IDX;
  assign ys = vec_in.y >>> IDX;

  always_comb begin
    vec_nxt = vec_in;
    if (vec_in.y[XW-1]) begin
      vec_nxt.x   = vec_in.x - ys;
      vec_nxt.y   = vec_in.y + xs;
      vec_nxt.acc = vec_in.acc - ANGLE;
    end else begin
      vec_nxt.x   = vec_in.x + ys;
      vec_nxt.y   = vec_in.y - xs;
      vec_nxt.acc = vec_in.acc + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

endmodule

FILE: rtl/ghbb_decide.sv
// last stage: bearing rounding, heading error and the bang-bang command
// depends on ghbb_pkg; its registers drive the result ports
module ghbb_decide (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_in,
  input  ghbb_pkg::ghbb_vec_t    vec_in,
  input  ghbb_pkg::ghbb_cmd_cfg_t cfg,
  output logic                  valid_r,
  output logic [14:0]           linear_r,
  output logic [15:0]           angular_r,
  output logic                  facing_r,
  output logic [15:0]           error_r
);
  import ghbb_pkg::*;

  logic [ACC_W-1:0]   rounded;
  logic [15:0]        bearing, diff;
  logic signed [16:0] err, tol;
  logic [14:0]        linear_nxt;
  logic [15:0]        angular_nxt;
  logic               facing_nxt;

  always_comb begin
    rounded = vec_in.acc + 32'h00008000;
    bearing = vec_in.zero ? 16'h0 : rounded[31:16];
    diff    = bearing - vec_in.heading;
    err     = {diff[15], diff};
    tol     = {2'b00, cfg.tolerance};
    if (err > tol) begin
      linear_nxt  = '0;
      angular_nxt = {1'b0, cfg.turn_rate};
      facing_nxt  = 1'b0;
    end else if (err < -tol) begin
      linear_nxt  = '0;
      angular_nxt = -{1'b0, cfg.turn_rate};
      facing_nxt  = 1'b0;
    end else begin
      linear_nxt  = cfg.drive_speed;
      angular_nxt = '0;
      facing_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      linear_r  <= linear_nxt;
      angular_r <= angular_nxt;
      facing_r  <= facing_nxt;
      error_r   <= diff;
    end
  end

endmodule

FILE: rtl/goal_heading_bang_bang.sv
// top level of the bearing-to-goal bang-bang heading controller
// depends on ghbb_pkg, ghbb_prep, ghbb_cordic_stage, ghbb_decide and the macro header
//
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall  pos_x, pos_y, heading
// out_     output     out_valid / out_stall linear_cmd, angular_cmd, facing, bearing_error
// cfg      apb        psel/penable/pready  five registers at 4*index
//
// pipeline: prep stage, one cordic stage per iteration, decision stage; one request
// per cycle sustained while out_stall is low
// each stage holds when it is full and the one after it cannot take, so bubbles close up
// rst_n is synchronous: pipeline empty, registers at their documented reset values
`include "goal_heading_bang_bang_macros.svh"
module goal_heading_bang_bang #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [15:0] in_heading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_linear_cmd,
  output logic [15:0] out_angular_cmd,
  output logic        out_facing,
  output logic [15:0] out_bearing_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ghbb_pkg::*;

  localparam int NS = (CORDIC_STAGES > ATAN_N) ? ATAN_N : CORDIC_STAGES;

  logic [15:0]   goal_x_r, goal_y_r;
  logic [14:0]   tolerance_r, turn_rate_r, drive_speed_r;
  logic          wr_en;
  logic [2:0]    reg_idx;
  ghbb_cmd_cfg_t cmd_cfg;

  logic      stage_valid [NS+1];
  ghbb_vec_t stage_vec   [NS+1];
  logic      ready       [NS+2];

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r      <= 16'd0;
      goal_y_r      <= 16'd0;
      tolerance_r   <= 15'd1456;
      turn_rate_r   <= 15'd200;
      drive_speed_r <= 15'd200;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GOAL_X:    goal_x_r      <= pwdata[15:0];
        REG_GOAL_Y:    goal_y_r      <= pwdata[15:0];
        REG_TOLERANCE: tolerance_r   <= pwdata[14:0];
        REG_TURN_RATE: turn_rate_r   <= pwdata[14:0];
        REG_DRIVE:     drive_speed_r <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GOAL_X:    prdata = {16'd0, goal_x_r};
      REG_GOAL_Y:    prdata = {16'd0, goal_y_r};
      REG_TOLERANCE: prdata = {17'd0, tolerance_r};
      REG_TURN_RATE: prdata = {17'd0, turn_rate_r};
      REG_DRIVE:     prdata = {17'd0, drive_speed_r};
      default:       prdata = 32'd0;
    endcase
  end

  assign cmd_cfg.tolerance   = tolerance_r;
  assign cmd_cfg.turn_rate   = turn_rate_r;
  assign cmd_cfg.drive_speed = drive_speed_r;

  // per-stage advance, closing bubbles
  assign ready[NS+1] = !out_valid || !out_stall;
  genvar k;
  generate
    for (k = 0; k <= NS; k++) begin : g_ready
      assign ready[k] = !stage_valid[k] || ready[k+1];
    end
  endgenerate

  assign in_stall = !ready[0];

  ghbb_prep #(
    .COORD_BITS(COORD_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (ready[0]),
    .in_valid(in_valid),
    .pos_x   (in_pos_x),
    .pos_y   (in_pos_y),
    .heading (in_heading),
    .goal_x  (goal_x_r),
    .goal_y  (goal_y_r),
    .valid_r (stage_valid[0]),
    .vec_r   (stage_vec[0])
  );

  generate
    for (k = 0; k < NS; k++) begin : g_cordic
      ghbb_cordic_stage #(
        .IDX(k)
      ) u_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (ready[k+1]),
        .valid_in(stage_valid[k]),
        .vec_in  (stage_vec[k]),
        .valid_r (stage_valid[k+1]),
        .vec_r   (stage_vec[k+1])
      );
    end
  endgenerate

  ghbb_decide u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (ready[NS+1]),
    .valid_in (stage_valid[NS]),
    .vec_in   (stage_vec[NS]),
    .cfg      (cmd_cfg),
    .valid_r  (out_valid),
    .linear_r (out_linear_cmd),
    .angular_r(out_angular_cmd),
    .facing_r (out_facing),
    .error_r  (out_bearing_error)
  );

  // facing band gives drive only, outside it turn only
  `GHBB_ASSERT_IMPLY(a_facing_no_turn, out_valid && out_facing, out_angular_cmd == 16'd0)
  `GHBB_ASSERT_IMPLY(a_turning_no_drive, out_valid && !out_facing, out_linear_cmd == 15'd0)
  // half-turn error always falls outside the band
  `GHBB_ASSERT_IMPLY(a_half_turn_cw, out_valid && (out_bearing_error == 16'h8000), !out_facing)
  // input only held back when the result side is blocked
  `GHBB_ASSERT_IMPLY(a_stall_from_output, in_stall, out_valid && out_stall)

endmodule
